// ===== rtl/gf2_sparse_matvec_xor_assert.svh =====
// Assertion macros used by the checker file of this block.
`ifndef GF2_SPARSE_MATVEC_XOR_ASSERT_SVH
`define GF2_SPARSE_MATVEC_XOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GSMX_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gsmx assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GSMX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gsmx assertion failed");

`endif

// ===== rtl/gsmx_pkg.sv =====
`default_nettype none

package gsmx_pkg;

  localparam int unsigned VECTOR_DEPTH_DEF = 65536;
  localparam int unsigned VSIZE_W          = 17;
  localparam logic [VSIZE_W-1:0] VSIZE_RESET = 17'h10000;

  typedef enum logic [1:0] {
    MODE_WRITE  = 2'd0,
    MODE_HEADER = 2'd1,
    MODE_INDEX  = 2'd2,
    MODE_READ   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_ROW   = 2'd0,
    KIND_READ  = 2'd1,
    KIND_RANGE = 2'd2,
    KIND_NOROW = 2'd3
  } kind_e;

  typedef enum logic [0:0] {
    CFG_TRANSPOSE = 1'b0,
    CFG_VSIZE     = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    mode_e       mode;
    logic [31:0] index;
    logic [31:0] row_length;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] result_word;
    logic [31:0] row_number;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic clr_wr;
    logic accept;
    logic exec;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clr_last;
    logic emit;
    logic out_space;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/gsmx_ram.sv =====
`default_nettype none

module gsmx_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/gsmx_ctrl.sv =====
`default_nettype none

module gsmx_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire gsmx_pkg::status_t status_i,
  output logic                   in_ready_o,
  output gsmx_pkg::cmd_t         cmd_o
);

  import gsmx_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        // An item that produces a result waits here for room in the output register.
        if (!status_i.emit || status_i.out_space) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clr_wr = 1'b1;
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_EXEC: cmd_o.exec = !status_i.emit || status_i.out_space;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/gsmx_dp.sv =====
`default_nettype none

module gsmx_dp #(
  parameter int unsigned VECTOR_DEPTH = gsmx_pkg::VECTOR_DEPTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire gsmx_pkg::cfg_idx_e                  cfg_index_i,
  input  wire logic [gsmx_pkg::VSIZE_W-1:0]        cfg_wdata_i,
  input  wire gsmx_pkg::in_item_t                  in_data_i,
  input  wire logic                                out_ready_i,
  input  wire gsmx_pkg::cmd_t                      cmd_i,
  output gsmx_pkg::status_t                        status_o,
  output logic                                     out_valid_o,
  output gsmx_pkg::out_item_t                      out_data_o
);

  import gsmx_pkg::*;

  localparam int unsigned AW = $clog2(VECTOR_DEPTH);
  localparam logic [32:0] DEPTH_W = 33'(VECTOR_DEPTH);
  localparam logic [AW-1:0] CLR_LAST = AW'(VECTOR_DEPTH - 1);

  logic              transpose_q;
  logic [VSIZE_W-1:0] vsize_q;
  in_item_t          item_q;
  logic              inr_q;
  logic [63:0]       acc_q, acc_d;
  logic [63:0]       rw_q, rw_d;
  logic [31:0]       left_q, left_d;
  logic [31:0]       rows_q, rows_d;
  logic [AW-1:0]     clr_cnt_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic              in_range;
  logic [63:0]       rdata;
  logic [63:0]       acc_new;
  logic              emit;
  logic              wr_req;
  logic [63:0]       wr_data;
  out_item_t         res;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [63:0]       ram_wdata;

  // The limit is the smaller of the register and the store depth.
  assign in_range = ({1'b0, in_data_i.index} < {16'b0, vsize_q})
                 && ({1'b0, in_data_i.index} < DEPTH_W);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      transpose_q <= 1'b0;
      vsize_q     <= VSIZE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TRANSPOSE: transpose_q <= cfg_wdata_i[0];
        CFG_VSIZE:     vsize_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= in_data_i;
      inr_q  <= in_range;
    end
  end

  assign ram_we    = cmd_i.clr_wr || (cmd_i.exec && wr_req);
  assign ram_waddr = cmd_i.clr_wr ? clr_cnt_q : item_q.index[AW-1:0];
  assign ram_wdata = cmd_i.clr_wr ? 64'd0 : wr_data;

  gsmx_ram #(
    .WIDTH (64),
    .DEPTH (VECTOR_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (in_data_i.index[AW-1:0]),
    .rdata_o (rdata)
  );

  assign acc_new = inr_q ? (acc_q ^ rdata) : acc_q;

  always_comb begin
    acc_d   = acc_q;
    rw_d    = rw_q;
    left_d  = left_q;
    rows_d  = rows_q;
    emit    = 1'b0;
    wr_req  = 1'b0;
    wr_data = item_q.value;
    res     = '{kind: KIND_ROW, result_word: 64'd0, row_number: 32'd0};
    unique case (item_q.mode)
      MODE_WRITE: begin
        if (!inr_q) begin
          emit     = 1'b1;
          res.kind = KIND_RANGE;
        end else begin
          wr_req = 1'b1;
        end
      end
      MODE_READ: begin
        emit = 1'b1;
        if (!inr_q) begin
          res.kind = KIND_RANGE;
        end else begin
          res.kind        = KIND_READ;
          res.result_word = rdata;
        end
      end
      MODE_HEADER: begin
        // A header abandons any open row.
        rows_d = rows_q + 32'd1;
        acc_d  = 64'd0;
        rw_d   = item_q.value;
        left_d = item_q.row_length;
        if ((item_q.row_length == 32'd0) && !transpose_q) begin
          emit           = 1'b1;
          res.row_number = rows_q;
        end
      end
      MODE_INDEX: begin
        if (left_q == 32'd0) begin
          emit     = 1'b1;
          res.kind = KIND_NOROW;
        end else begin
          left_d = left_q - 32'd1;
          if (transpose_q) begin
            if (!inr_q) begin
              emit     = 1'b1;
              res.kind = KIND_RANGE;
            end else begin
              wr_req  = 1'b1;
              wr_data = rdata ^ rw_q;
            end
          end else begin
            acc_d = acc_new;
            // The last index of a row gives the row result even when it is dropped.
            if (left_q == 32'd1) begin
              emit            = 1'b1;
              res.result_word = acc_new;
              res.row_number  = rows_q - 32'd1;
            end else if (!inr_q) begin
              emit     = 1'b1;
              res.kind = KIND_RANGE;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= 64'd0;
      rw_q      <= 64'd0;
      left_q    <= 32'd0;
      rows_q    <= 32'd0;
      clr_cnt_q <= '0;
    end else begin
      if (cmd_i.exec) begin
        acc_q  <= acc_d;
        rw_q   <= rw_d;
        left_q <= left_d;
        rows_q <= rows_d;
      end
      if (cmd_i.clr_wr) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && emit) begin
      out_q <= res;
    end
  end

  assign status_o.clr_last  = (clr_cnt_q == CLR_LAST);
  assign status_o.emit      = emit;
  assign status_o.out_space = !out_valid_q || out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;

endmodule

`default_nettype wire

// ===== rtl/gf2_sparse_matvec_xor.sv =====
// Channel   Signals                           Moves
// input     in_valid_i in_ready_o in_data_i   one item: mode, index, row_length, value
// output    out_valid_o out_ready_i out_data_o one item: kind, result_word, row_number
// config    cfg_we_i cfg_index_i cfg_wdata_i  register write, no handshake
//
// Each item passes through an accept state, which takes it and issues the store
// read, and then an execute state, which updates the store or the row state from
// the registered read data. After reset a clearing pass zeroes every store entry;
// no item is accepted meanwhile, but configuration writes are taken.
// An item that gives a result holds in its execute state while the output register is
// full and not being emptied; items without a result never stall.
`default_nettype none

module gf2_sparse_matvec_xor #(
  parameter int unsigned VECTOR_DEPTH = gsmx_pkg::VECTOR_DEPTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire gsmx_pkg::cfg_idx_e           cfg_index_i,
  input  wire logic [gsmx_pkg::VSIZE_W-1:0] cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire gsmx_pkg::in_item_t           in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output gsmx_pkg::out_item_t               out_data_o
);

  import gsmx_pkg::*;

  cmd_t    cmd;
  status_t status;

  gsmx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  gsmx_dp #(
    .VECTOR_DEPTH (VECTOR_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== rtl/gsmx_chk.sv =====
`default_nettype none
`include "gf2_sparse_matvec_xor_assert.svh"

module gsmx_chk (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire gsmx_pkg::out_item_t          out_data_o
);

  // A result waits in the output register until it is taken.
  `GSMX_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `GSMX_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i,
                    $stable(out_data_o))
  // Only one item is in flight, so ready drops right after an accept.
  `GSMX_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  // A fresh result always follows an earlier accepted item.
  `GSMX_ASSERT_IMPL(a_out_cause, clk_i, rst_ni, $rose(out_valid_o),
                    $past(in_valid_i && in_ready_o, 2))

endmodule

bind gf2_sparse_matvec_xor gsmx_chk u_chk (.*);

`default_nettype wire
